[hdl/pbc_pkg.sv]
// Shared constants, types and term-ordering helpers for the polynomial background corrector.
// No dependencies; every other file refers to this package by scoped names.
package pbc_pkg;

    localparam int MAX_DEGREE  = 3;
    localparam int COORD_BITS  = 10;
    localparam int POS_W       = 10;
    localparam int IDX_W       = 4;
    localparam int TAB_DEPTH   = 16;
    localparam int COEF_W      = 64;
    localparam int PIX_W       = 32;
    localparam int DEG_W       = 2;
    localparam int CFG_W       = 2;

    localparam int NTERMS      = (MAX_DEGREE + 1) * (MAX_DEGREE + 2) / 2;
    localparam int MONO_W      = (MAX_DEGREE == 0) ? 1 : MAX_DEGREE * COORD_BITS;
    localparam int MONO_STAGES = (MAX_DEGREE == 0) ? 1 : MAX_DEGREE;
    localparam int TERM_W      = COEF_W + MONO_W + 1;
    localparam int TREE_LVLS   = (NTERMS > 1) ? $clog2(NTERMS) : 1;
    localparam int TREE_LEAVES = 1 << TREE_LVLS;
    localparam int SUM_W       = TERM_W + TREE_LVLS + 1;

    // Q.40 sum to Q16.16
    localparam int FRAC_SHIFT  = 24;
    localparam int ROUND_HALF  = 1 << (FRAC_SHIFT - 1);

    localparam int NUM_W       = PIX_W + 16;
    localparam int REM_W       = PIX_W + 1;
    localparam int DIV_BITS    = 4;
    localparam int DIV_STAGES  = NUM_W / DIV_BITS;

    localparam logic signed [PIX_W-1:0] PIX_MAX = {1'b0, {(PIX_W-1){1'b1}}};
    localparam logic signed [PIX_W-1:0] PIX_MIN = {1'b1, {(PIX_W-1){1'b0}}};

    typedef enum logic {MODE_LOAD = 1'b0, MODE_PIXEL = 1'b1} mode_t;
    typedef enum logic {KIND_SUBTRACT = 1'b0, KIND_DIVIDE = 1'b1} kind_t;
    typedef enum logic {REG_DEGREE = 1'b0, REG_KIND = 1'b1} reg_idx_t;

    // background request handed from the evaluator to the correction pipeline
    typedef struct packed {
        logic                    valid;
        logic signed [PIX_W-1:0] pix;
        logic signed [PIX_W-1:0] bg;
        logic                    bg_ov;
    } bg_req_t;

    // x exponent of hardware term slot k (i outer, j inner, full degree)
    function automatic int term_i(input int k);
        int n;
        int r;
        n = 0;
        r = 0;
        for (int i = 0; i <= MAX_DEGREE; i++) begin
            for (int j = 0; i + j <= MAX_DEGREE; j++) begin
                if (n == k) r = i;
                n++;
            end
        end
        return r;
    endfunction

    function automatic int term_j(input int k);
        int n;
        int r;
        n = 0;
        r = 0;
        for (int i = 0; i <= MAX_DEGREE; i++) begin
            for (int j = 0; i + j <= MAX_DEGREE; j++) begin
                if (n == k) r = j;
                n++;
            end
        end
        return r;
    endfunction

    // table slot holding the coefficient of x^i y^j when running at degree d
    function automatic logic [IDX_W-1:0] coef_slot(input int d, input int i, input int j);
        int k;
        k = i * (d + 1) - ((i * (i - 1)) >> 1) + j;
        return IDX_W'(k);
    endfunction

endpackage

[hdl/pbc_eval.sv]
// Background evaluator: input register, monomial chain, coefficient table, products,
// registered adder tree and Q16.16 rounding/saturation. Depends on pbc_pkg.
module pbc_eval (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                adv,
    input  logic                                in_valid,
    input  logic                                in_mode,
    input  logic [pbc_pkg::IDX_W-1:0]           in_idx,
    input  logic signed [pbc_pkg::COEF_W-1:0]   in_value,
    input  logic [pbc_pkg::POS_W-1:0]           in_x,
    input  logic [pbc_pkg::POS_W-1:0]           in_y,
    input  logic signed [pbc_pkg::PIX_W-1:0]    in_pix,
    input  logic [pbc_pkg::DEG_W-1:0]           degree,
    output pbc_pkg::bg_req_t                    bg_out
);

    localparam int MS  = pbc_pkg::MONO_STAGES;
    localparam int NT  = pbc_pkg::NTERMS;
    localparam int MW  = pbc_pkg::MONO_W;
    localparam int CW  = pbc_pkg::COORD_BITS;
    localparam int SW  = pbc_pkg::SUM_W;
    localparam int TL  = pbc_pkg::TREE_LEAVES;
    localparam int LV  = pbc_pkg::TREE_LVLS;
    localparam int PW  = pbc_pkg::PIX_W;
    localparam int KW  = pbc_pkg::COEF_W;
    localparam int HW  = KW / 2;

    // input register
    logic                      v0_reg;
    logic                      mode0_reg;
    logic [pbc_pkg::IDX_W-1:0] idx0_reg;
    logic signed [KW-1:0]      val0_reg;
    logic [CW-1:0]             x0_reg, y0_reg;
    logic signed [PW-1:0]      pix0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mode0_reg <= in_mode;
            idx0_reg  <= in_idx;
            val0_reg  <= in_value;
            x0_reg    <= CW'(in_x);
            y0_reg    <= CW'(in_y);
            pix0_reg  <= in_pix;
        end
    end

    // monomial chain: step s multiplies term (i,j) by x while s < i, then by y
    logic [MS-1:0]             mv_reg;
    logic                      mmode_reg [MS];
    logic [pbc_pkg::IDX_W-1:0] midx_reg  [MS];
    logic signed [KW-1:0]      mval_reg  [MS];
    logic [CW-1:0]             mx_reg    [MS];
    logic [CW-1:0]             my_reg    [MS];
    logic signed [PW-1:0]      mpix_reg  [MS];
    logic [MW-1:0]             mono_reg  [MS][NT];
    logic [MW-1:0]             mono_next [MS][NT];

    logic                      sv    [MS];
    logic                      smode [MS];
    logic [pbc_pkg::IDX_W-1:0] sidx  [MS];
    logic signed [KW-1:0]      sval  [MS];
    logic [CW-1:0]             sx    [MS];
    logic [CW-1:0]             sy    [MS];
    logic signed [PW-1:0]      spix  [MS];
    logic [MW-1:0]             msrc  [MS][NT];

    genvar g, t;
    generate
        for (g = 0; g < MS; g++) begin : g_mono
            if (g == 0) begin : g_first
                assign sv[g]    = v0_reg;
                assign smode[g] = mode0_reg;
                assign sidx[g]  = idx0_reg;
                assign sval[g]  = val0_reg;
                assign sx[g]    = x0_reg;
                assign sy[g]    = y0_reg;
                assign spix[g]  = pix0_reg;
                for (t = 0; t < NT; t++) begin : g_one
                    assign msrc[g][t] = MW'(1);
                end
            end else begin : g_rest
                assign sv[g]    = mv_reg[g-1];
                assign smode[g] = mmode_reg[g-1];
                assign sidx[g]  = midx_reg[g-1];
                assign sval[g]  = mval_reg[g-1];
                assign sx[g]    = mx_reg[g-1];
                assign sy[g]    = my_reg[g-1];
                assign spix[g]  = mpix_reg[g-1];
                for (t = 0; t < NT; t++) begin : g_prev
                    assign msrc[g][t] = mono_reg[g-1][t];
                end
            end

            always_comb begin
                for (int k = 0; k < NT; k++) begin
                    if (g < pbc_pkg::term_i(k)) begin
                        mono_next[g][k] = MW'(msrc[g][k] * sx[g]);
                    end else if (g < pbc_pkg::term_i(k) + pbc_pkg::term_j(k)) begin
                        mono_next[g][k] = MW'(msrc[g][k] * sy[g]);
                    end else begin
                        mono_next[g][k] = msrc[g][k];
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    mv_reg[g] <= 1'b0;
                end else if (adv) begin
                    mv_reg[g] <= sv[g];
                end
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    mmode_reg[g] <= smode[g];
                    midx_reg[g]  <= sidx[g];
                    mval_reg[g]  <= sval[g];
                    mx_reg[g]    <= sx[g];
                    my_reg[g]    <= sy[g];
                    mpix_reg[g]  <= spix[g];
                    for (int k = 0; k < NT; k++) begin
                        mono_reg[g][k] <= mono_next[g][k];
                    end
                end
            end
        end
    endgenerate

    // coefficient table: loads write here, in stream order with the pixel reads
    logic signed [KW-1:0]      coef_reg [pbc_pkg::TAB_DEPTH];
    logic [pbc_pkg::DEG_W-1:0] deg_eff;
    logic signed [KW-1:0]      csel [NT];
    logic                      at_load;

    assign deg_eff = (int'(degree) > pbc_pkg::MAX_DEGREE) ?
                     pbc_pkg::DEG_W'(pbc_pkg::MAX_DEGREE) : degree;
    assign at_load = mv_reg[MS-1] && (mmode_reg[MS-1] == pbc_pkg::MODE_LOAD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int e = 0; e < pbc_pkg::TAB_DEPTH; e++) begin
                coef_reg[e] <= '0;
            end
        end else if (adv && at_load) begin
            coef_reg[midx_reg[MS-1]] <= mval_reg[MS-1];
        end
    end

    // each slot picks among fixed entries, one per degree
    always_comb begin
        for (int k = 0; k < NT; k++) begin
            csel[k] = '0;
            for (int d = 0; d <= pbc_pkg::MAX_DEGREE; d++) begin
                if (int'(deg_eff) == d && pbc_pkg::term_i(k) + pbc_pkg::term_j(k) <= d) begin
                    csel[k] = coef_reg[pbc_pkg::coef_slot(d, pbc_pkg::term_i(k),
                                                          pbc_pkg::term_j(k))];
                end
            end
        end
    end

    // partial products: low half unsigned, high half signed
    logic                      pv_reg;
    logic signed [PW-1:0]      ppix_reg;
    logic [HW+MW-1:0]          plo_reg  [NT];
    logic signed [HW+MW:0]     phi_reg  [NT];
    logic [HW+MW-1:0]          plo_next [NT];
    logic signed [HW+MW:0]     phi_next [NT];

    always_comb begin
        for (int k = 0; k < NT; k++) begin
            plo_next[k] = csel[k][HW-1:0] * mono_reg[MS-1][k];
            phi_next[k] = $signed(csel[k][KW-1:HW]) * $signed({1'b0, mono_reg[MS-1][k]});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
        end else if (adv) begin
            pv_reg <= mv_reg[MS-1] && (mmode_reg[MS-1] == pbc_pkg::MODE_PIXEL);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ppix_reg <= mpix_reg[MS-1];
            for (int k = 0; k < NT; k++) begin
                plo_reg[k] <= plo_next[k];
                phi_reg[k] <= phi_next[k];
            end
        end
    end

    // leaves: full term, sign-extended to tree width
    logic                 lv_reg;
    logic signed [PW-1:0] lpix_reg;
    logic signed [SW-1:0] leaf_reg  [TL];
    logic signed [SW-1:0] leaf_next [TL];

    generate
        for (t = 0; t < TL; t++) begin : g_leaf
            if (t < NT) begin : g_term
                assign leaf_next[t] = SW'($signed({phi_reg[t], {HW{1'b0}}})
                                          + $signed({1'b0, plo_reg[t]}));
            end else begin : g_pad
                assign leaf_next[t] = '0;
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lv_reg <= 1'b0;
        end else if (adv) begin
            lv_reg <= pv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            lpix_reg <= ppix_reg;
            for (int k = 0; k < TL; k++) begin
                leaf_reg[k] <= leaf_next[k];
            end
        end
    end

    // registered adder tree, one pairwise level per stage
    logic [LV-1:0]        tv_reg;
    logic signed [PW-1:0] tpix_reg [LV];
    logic signed [SW-1:0] tree_reg [LV][TL/2];

    genvar l, n;
    generate
        for (l = 0; l < LV; l++) begin : g_lvl
            if (l == 0) begin : g_base
                always_ff @(posedge aclk) begin
                    if (!aresetn) begin
                        tv_reg[l] <= 1'b0;
                    end else if (adv) begin
                        tv_reg[l] <= lv_reg;
                    end
                end
                always_ff @(posedge aclk) begin
                    if (adv) begin
                        tpix_reg[l] <= lpix_reg;
                    end
                end
                for (n = 0; n < (TL >> 1); n++) begin : g_node
                    always_ff @(posedge aclk) begin
                        if (adv) begin
                            tree_reg[l][n] <= leaf_reg[2*n] + leaf_reg[2*n+1];
                        end
                    end
                end
            end else begin : g_up
                always_ff @(posedge aclk) begin
                    if (!aresetn) begin
                        tv_reg[l] <= 1'b0;
                    end else if (adv) begin
                        tv_reg[l] <= tv_reg[l-1];
                    end
                end
                always_ff @(posedge aclk) begin
                    if (adv) begin
                        tpix_reg[l] <= tpix_reg[l-1];
                    end
                end
                for (n = 0; n < (TL >> (l + 1)); n++) begin : g_node
                    always_ff @(posedge aclk) begin
                        if (adv) begin
                            tree_reg[l][n] <= tree_reg[l-1][2*n] + tree_reg[l-1][2*n+1];
                        end
                    end
                end
            end
        end
    endgenerate

    // round to nearest (ties up), drop 24 fraction bits, saturate to 32 bits
    logic signed [SW-1:0] rnd_sum;
    logic signed [SW-1:0] shifted;
    logic                 fits;
    logic signed [PW-1:0] bg_next;

    assign rnd_sum = tree_reg[LV-1][0] + $signed(SW'(pbc_pkg::ROUND_HALF));
    assign shifted = rnd_sum >>> pbc_pkg::FRAC_SHIFT;
    assign fits    = (&shifted[SW-1:PW-1]) || !(|shifted[SW-1:PW-1]);
    assign bg_next = fits ? shifted[PW-1:0] :
                     (shifted[SW-1] ? pbc_pkg::PIX_MIN : pbc_pkg::PIX_MAX);

    logic                 bgv_reg;
    logic signed [PW-1:0] bg_reg;
    logic                 bgov_reg;
    logic signed [PW-1:0] bgpix_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bgv_reg <= 1'b0;
        end else if (adv) begin
            bgv_reg <= tv_reg[LV-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            bg_reg    <= bg_next;
            bgov_reg  <= !fits;
            bgpix_reg <= tpix_reg[LV-1];
        end
    end

    assign bg_out.valid = bgv_reg;
    assign bg_out.pix   = bgpix_reg;
    assign bg_out.bg    = bg_reg;
    assign bg_out.bg_ov = bgov_reg;

endmodule

[hdl/pbc_div.sv]
// Correction pipeline: subtraction, pipelined restoring divider (four bits a stage)
// and the output register with saturation. Depends on pbc_pkg.
module pbc_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              adv,
    input  pbc_pkg::bg_req_t                  req,
    input  pbc_pkg::kind_t                    kind,
    output logic                              m_valid,
    output logic signed [pbc_pkg::PIX_W-1:0]  m_corrected,
    output logic signed [pbc_pkg::PIX_W-1:0]  m_background,
    output logic                              m_overflow
);

    localparam int PW = pbc_pkg::PIX_W;
    localparam int NW = pbc_pkg::NUM_W;
    localparam int RW = pbc_pkg::REM_W;
    localparam int DS = pbc_pkg::DIV_STAGES;
    localparam int DB = pbc_pkg::DIV_BITS;

    // set-up stage
    logic signed [PW:0]   diff;
    logic                 diff_fits;
    logic [PW-1:0]        pmag, dmag;

    assign diff      = {req.pix[PW-1], req.pix} - {req.bg[PW-1], req.bg};
    assign diff_fits = (diff[PW] == diff[PW-1]);
    assign pmag      = req.pix[PW-1] ? PW'(-req.pix) : req.pix;
    assign dmag      = req.bg[PW-1] ? PW'(-req.bg) : req.bg;

    logic                 v0_reg;
    logic                 psign0_reg, neg0_reg, bgz0_reg, bgov0_reg, subov0_reg;
    logic signed [PW-1:0] bg0_reg, sub0_reg;
    logic [PW-1:0]        d0_reg;
    logic [NW-1:0]        num0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= req.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            psign0_reg <= req.pix[PW-1];
            neg0_reg   <= req.pix[PW-1] ^ req.bg[PW-1];
            bgz0_reg   <= (req.bg == '0);
            bgov0_reg  <= req.bg_ov;
            subov0_reg <= !diff_fits;
            bg0_reg    <= req.bg;
            sub0_reg   <= diff_fits ? diff[PW-1:0] :
                          (diff[PW] ? pbc_pkg::PIX_MIN : pbc_pkg::PIX_MAX);
            d0_reg     <= dmag;
            num0_reg   <= {pmag, {(NW-PW){1'b0}}};
        end
    end

    // divider stages; num holds the unused dividend bits and the growing quotient
    logic [DS-1:0]        dv_reg;
    logic                 psign_reg [DS];
    logic                 neg_reg   [DS];
    logic                 bgz_reg   [DS];
    logic                 bgov_reg  [DS];
    logic                 subov_reg [DS];
    logic signed [PW-1:0] bg_reg    [DS];
    logic signed [PW-1:0] sub_reg   [DS];
    logic [PW-1:0]        d_reg     [DS];
    logic [NW-1:0]        num_reg   [DS];
    logic [RW-1:0]        rem_reg   [DS];

    genvar g;
    generate
        for (g = 0; g < DS; g++) begin : g_stage
            logic                 s_v, s_psign, s_neg, s_bgz, s_bgov, s_subov;
            logic signed [PW-1:0] s_bg, s_sub;
            logic [PW-1:0]        s_d;
            logic [NW-1:0]        s_num, q_next;
            logic [RW-1:0]        s_rem, r_next;

            if (g == 0) begin : g_first
                assign s_v     = v0_reg;
                assign s_psign = psign0_reg;
                assign s_neg   = neg0_reg;
                assign s_bgz   = bgz0_reg;
                assign s_bgov  = bgov0_reg;
                assign s_subov = subov0_reg;
                assign s_bg    = bg0_reg;
                assign s_sub   = sub0_reg;
                assign s_d     = d0_reg;
                assign s_num   = num0_reg;
                assign s_rem   = '0;
            end else begin : g_rest
                assign s_v     = dv_reg[g-1];
                assign s_psign = psign_reg[g-1];
                assign s_neg   = neg_reg[g-1];
                assign s_bgz   = bgz_reg[g-1];
                assign s_bgov  = bgov_reg[g-1];
                assign s_subov = subov_reg[g-1];
                assign s_bg    = bg_reg[g-1];
                assign s_sub   = sub_reg[g-1];
                assign s_d     = d_reg[g-1];
                assign s_num   = num_reg[g-1];
                assign s_rem   = rem_reg[g-1];
            end

            always_comb begin
                r_next = s_rem;
                q_next = s_num;
                for (int b = 0; b < DB; b++) begin
                    r_next = {r_next[RW-2:0], q_next[NW-1]};
                    q_next = {q_next[NW-2:0], 1'b0};
                    if (r_next >= {1'b0, s_d}) begin
                        r_next    = r_next - {1'b0, s_d};
                        q_next[0] = 1'b1;
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    dv_reg[g] <= 1'b0;
                end else if (adv) begin
                    dv_reg[g] <= s_v;
                end
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    psign_reg[g] <= s_psign;
                    neg_reg[g]   <= s_neg;
                    bgz_reg[g]   <= s_bgz;
                    bgov_reg[g]  <= s_bgov;
                    subov_reg[g] <= s_subov;
                    bg_reg[g]    <= s_bg;
                    sub_reg[g]   <= s_sub;
                    d_reg[g]     <= s_d;
                    num_reg[g]   <= q_next;
                    rem_reg[g]   <= r_next;
                end
            end
        end
    endgenerate

    // final selection and saturation
    logic [NW-1:0]        q;
    logic signed [PW-1:0] cor_next;
    logic                 ov_next;
    logic                 q_pos_big, q_neg_big;

    assign q         = num_reg[DS-1];
    assign q_pos_big = |q[NW-1:PW-1];
    assign q_neg_big = (|q[NW-1:PW]) || (q[PW-1] && (|q[PW-2:0]));

    always_comb begin
        if (kind == pbc_pkg::KIND_SUBTRACT) begin
            cor_next = sub_reg[DS-1];
            ov_next  = bgov_reg[DS-1] || subov_reg[DS-1];
        end else if (bgz_reg[DS-1]) begin
            cor_next = psign_reg[DS-1] ? pbc_pkg::PIX_MIN : pbc_pkg::PIX_MAX;
            ov_next  = 1'b1;
        end else if (neg_reg[DS-1]) begin
            cor_next = q_neg_big ? pbc_pkg::PIX_MIN : PW'(-q[PW-1:0]);
            ov_next  = bgov_reg[DS-1] || q_neg_big;
        end else begin
            cor_next = q_pos_big ? pbc_pkg::PIX_MAX : q[PW-1:0];
            ov_next  = bgov_reg[DS-1] || q_pos_big;
        end
    end

    logic                 out_v_reg;
    logic signed [PW-1:0] out_cor_reg, out_bg_reg;
    logic                 out_ov_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (adv) begin
            out_v_reg <= dv_reg[DS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_cor_reg <= cor_next;
            out_bg_reg  <= bg_reg[DS-1];
            out_ov_reg  <= ov_next;
        end
    end

    assign m_valid      = out_v_reg;
    assign m_corrected  = out_cor_reg;
    assign m_background = out_bg_reg;
    assign m_overflow   = out_ov_reg;

endmodule

[hdl/polynomial_background_correct.sv]
// Top level of the polynomial background corrector: config registers, stall control,
// evaluator and correction pipeline. Depends on pbc_pkg, pbc_eval and pbc_div.
//
//   channel   direction  handshake           payload
//   s_*       in         s_valid / s_ready   mode, coef_index, coef_value, pos_x, pos_y, pixel
//   m_*       out        m_valid / m_ready   corrected, background, overflow
//   cfg_*     in         cfg_we (no wait)    cfg_index, cfg_data
//
// One request per cycle sustained while the output is not stalled; the stages at the default constants are:
// input register, 3 monomial steps, product, term, 4 adder-tree levels, rounding,
// divide set-up, 12 divider stages of 4 quotient bits each, output register.
// The whole pipeline advances together whenever the output register is empty or taken,
// so a stall freezes every stage and nothing is lost or repeated.
// Reset (aresetn low, synchronous) clears all valid bits and the coefficient table,
// and sets degree to 3 and subtract mode. Load requests produce no result.
module polynomial_background_correct (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_mode,
    input  logic [pbc_pkg::IDX_W-1:0]           s_coef_index,
    input  logic signed [pbc_pkg::COEF_W-1:0]   s_coef_value,
    input  logic [pbc_pkg::POS_W-1:0]           s_pos_x,
    input  logic [pbc_pkg::POS_W-1:0]           s_pos_y,
    input  logic signed [pbc_pkg::PIX_W-1:0]    s_pixel,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [pbc_pkg::PIX_W-1:0]    m_corrected,
    output logic signed [pbc_pkg::PIX_W-1:0]    m_background,
    output logic                                m_overflow,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [pbc_pkg::CFG_W-1:0]           cfg_data
);

    // config registers
    logic [pbc_pkg::DEG_W-1:0] degree_reg;
    pbc_pkg::kind_t            kind_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            degree_reg <= pbc_pkg::DEG_W'(3);
            kind_reg   <= pbc_pkg::KIND_SUBTRACT;
        end else if (cfg_we) begin
            if (cfg_index == pbc_pkg::REG_DEGREE) begin
                degree_reg <= cfg_data[pbc_pkg::DEG_W-1:0];
            end else begin
                kind_reg   <= pbc_pkg::kind_t'(cfg_data[0]);
            end
        end
    end

    // global advance: output slot free or being emptied this cycle
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    pbc_pkg::bg_req_t bg_req;

    pbc_eval u_eval (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (s_valid),
        .in_mode  (s_mode),
        .in_idx   (s_coef_index),
        .in_value (s_coef_value),
        .in_x     (s_pos_x),
        .in_y     (s_pos_y),
        .in_pix   (s_pixel),
        .degree   (degree_reg),
        .bg_out   (bg_req)
    );

    pbc_div u_div (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .adv          (adv),
        .req          (bg_req),
        .kind         (kind_reg),
        .m_valid      (m_valid),
        .m_corrected  (m_corrected),
        .m_background (m_background),
        .m_overflow   (m_overflow)
    );

`ifndef NO_ASSERTIONS
    // zero background in divide mode: flagged, result pinned to a rail
    a_div_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && kind_reg == pbc_pkg::KIND_DIVIDE && m_background == '0
        |-> m_overflow && (m_corrected == pbc_pkg::PIX_MAX || m_corrected == pbc_pkg::PIX_MIN))
        else $error("zero background not flagged");

    // subtracting a zero background can never saturate
    a_sub_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && kind_reg == pbc_pkg::KIND_SUBTRACT && m_background == '0
        |-> !m_overflow)
        else $error("spurious overflow on zero background");

    // pipeline empty after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result present after reset");
`endif

endmodule
